@@ src/mmc_pkg.sv @@
// mmc_pkg: shared types and constants for the measurement mode controller
// command and mode codes, controller states, item and snapshot structs
// no dependencies
package mmc_pkg;

	typedef enum logic [2:0] {
		CMD_ACCEPT   = 3'd0,
		CMD_BEGIN    = 3'd1,
		CMD_COMPLETE = 3'd2,
		CMD_FAIL     = 3'd3,
		CMD_RECOVERY = 3'd4,
		CMD_FAULT    = 3'd5,
		CMD_READ     = 3'd6
	} cmd_op_t;

	typedef enum logic [1:0] {
		MODE_NONE        = 2'd0,
		MODE_CAPACITANCE = 2'd1,
		MODE_VOLTAGE     = 2'd2,
		MODE_RESISTANCE  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_UNINIT     = 4'd0,
		ST_SAFE       = 4'd1,
		ST_CAP        = 4'd2,
		ST_VOLT       = 4'd3,
		ST_RES        = 4'd4,
		ST_TRANSITION = 4'd5,
		ST_RECOVERY   = 4'd6,
		ST_DEGRADED   = 4'd7,
		ST_FAULT      = 4'd8
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]  command;
		mode_t       requested_mode;
		logic [31:0] request_id;
		logic [31:0] error_code;
		logic [31:0] frame_sequence;
		logic [63:0] duration_us;
	} cmd_item_t;

	typedef struct packed {
		ctrl_state_t state;
		mode_t       active;
		mode_t       old;
		mode_t       pend_mode;
		logic [31:0] pend_id;
		logic [31:0] applied_id;
		logic [31:0] frame;
		logic [63:0] duration;
		logic [31:0] gen;
		logic [31:0] error;
	} ctrl_regs_t;

	typedef struct packed {
		logic       accepted;
		ctrl_regs_t regs;
	} snap_item_t;

	localparam ctrl_regs_t REGS_RESET = '{
		state:      ST_SAFE,
		active:     MODE_NONE,
		old:        MODE_NONE,
		pend_mode:  MODE_NONE,
		pend_id:    32'd0,
		applied_id: 32'd0,
		frame:      32'd0,
		duration:   64'd0,
		gen:        32'd0,
		error:      32'd0
	};

endpackage

@@ src/mmc_if.sv @@
// mmc_cmd_if and mmc_snap_if: valid/ready channels for command and snapshot items
// plain logic payload fields, no package dependency
interface mmc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [1:0]  requested_mode;
	logic [31:0] request_id;
	logic [31:0] error_code;
	logic [31:0] frame_sequence;
	logic [63:0] duration_us;

	modport source (output valid, command, requested_mode, request_id, error_code,
		frame_sequence, duration_us, input ready);
	modport sink (input valid, command, requested_mode, request_id, error_code,
		frame_sequence, duration_us, output ready);
endinterface

interface mmc_snap_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [3:0]  cur_state;
	logic [1:0]  active_mode;
	logic [1:0]  previous_mode;
	logic [1:0]  waiting_mode;
	logic [31:0] waiting_id;
	logic [31:0] applied_id;
	logic [31:0] applied_frame;
	logic [63:0] last_duration_us;
	logic [31:0] generation_count;
	logic [31:0] recent_error;

	modport source (output valid, accepted, cur_state, active_mode, previous_mode,
		waiting_mode, waiting_id, applied_id, applied_frame, last_duration_us,
		generation_count, recent_error, input ready);
	modport sink (input valid, accepted, cur_state, active_mode, previous_mode,
		waiting_mode, waiting_id, applied_id, applied_frame, last_duration_us,
		generation_count, recent_error, output ready);
endinterface

@@ src/mmc_in_stage.sv @@
// mmc_in_stage: input register for command items
// depends on mmc_pkg and mmc_cmd_if
module mmc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	mmc_cmd_if.sink             cmd,
	input  logic                space,
	output logic                advance,
	output mmc_pkg::cmd_item_t  item_s1
);
	import mmc_pkg::*;

	logic valid_s1;

	assign advance   = valid_s1 && space;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.command        <= cmd.command;
			item_s1.requested_mode <= mode_t'(cmd.requested_mode);
			item_s1.request_id     <= cmd.request_id;
			item_s1.error_code     <= cmd.error_code;
			item_s1.frame_sequence <= cmd.frame_sequence;
			item_s1.duration_us    <= cmd.duration_us;
		end
	end
endmodule

@@ src/mmc_core.sv @@
// mmc_core: controller registers and guarded update for one command item
// depends on mmc_pkg
module mmc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  mmc_pkg::cmd_item_t  item,
	output mmc_pkg::snap_item_t snap
);
	import mmc_pkg::*;

	ctrl_regs_t regs_q;
	ctrl_regs_t regs_next;
	logic       ok;

	// next state
	always_comb begin
		regs_next = regs_q;
		ok        = 1'b0;
		case (cmd_op_t'(item.command))
			CMD_ACCEPT: begin
				if (item.requested_mode != MODE_NONE) begin
					regs_next.pend_mode = item.requested_mode;
					regs_next.pend_id   = item.request_id;
					ok                  = 1'b1;
				end
			end
			CMD_BEGIN: begin
				if (regs_q.pend_mode != MODE_NONE) begin
					regs_next.old   = regs_q.active;
					regs_next.state = ST_TRANSITION;
					regs_next.error = 32'd0;
					ok              = 1'b1;
				end
			end
			CMD_COMPLETE: begin
				if (regs_q.state == ST_TRANSITION && regs_q.pend_mode != MODE_NONE) begin
					regs_next.active     = regs_q.pend_mode;
					regs_next.state      = ctrl_state_t'({2'b00, regs_q.pend_mode} + 4'd1);
					regs_next.applied_id = regs_q.pend_id;
					regs_next.frame      = item.frame_sequence;
					regs_next.duration   = item.duration_us;
					regs_next.gen        = regs_q.gen + 32'd1;
					regs_next.pend_mode  = MODE_NONE;
					regs_next.pend_id    = 32'd0;
					ok                   = 1'b1;
				end
			end
			CMD_FAIL: begin
				regs_next.active     = MODE_NONE;
				regs_next.state      = ST_SAFE;
				regs_next.error      = item.error_code;
				regs_next.duration   = item.duration_us;
				regs_next.applied_id = regs_q.pend_id;
				regs_next.pend_mode  = MODE_NONE;
				regs_next.pend_id    = 32'd0;
				ok                   = 1'b1;
			end
			CMD_RECOVERY: begin
				regs_next.old       = regs_q.active;
				regs_next.active    = MODE_NONE;
				regs_next.state     = ST_RECOVERY;
				regs_next.error     = item.error_code;
				regs_next.pend_mode = MODE_NONE;
				regs_next.pend_id   = 32'd0;
				ok                  = 1'b1;
			end
			CMD_FAULT: begin
				regs_next.old    = regs_q.active;
				regs_next.active = MODE_NONE;
				regs_next.state  = ST_DEGRADED;
				regs_next.error  = item.error_code;
				ok               = 1'b1;
			end
			CMD_READ: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// snapshot after the command
	always_comb begin
		snap.accepted = ok;
		snap.regs     = regs_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REGS_RESET;
		end else if (advance) begin
			regs_q <= regs_next;
		end
	end
endmodule

@@ src/mmc_out_stage.sv @@
// mmc_out_stage: result register driving the snapshot channel
// depends on mmc_pkg and mmc_snap_if
module mmc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  mmc_pkg::snap_item_t snap,
	output logic                space,
	mmc_snap_if.source          rsp
);
	import mmc_pkg::*;

	logic       valid_q;
	snap_item_t snap_q;

	assign space     = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;

	assign rsp.accepted         = snap_q.accepted;
	assign rsp.cur_state        = 4'(snap_q.regs.state);
	assign rsp.active_mode      = 2'(snap_q.regs.active);
	assign rsp.previous_mode    = 2'(snap_q.regs.old);
	assign rsp.waiting_mode     = 2'(snap_q.regs.pend_mode);
	assign rsp.waiting_id       = snap_q.regs.pend_id;
	assign rsp.applied_id       = snap_q.regs.applied_id;
	assign rsp.applied_frame    = snap_q.regs.frame;
	assign rsp.last_duration_us = snap_q.regs.duration;
	assign rsp.generation_count = snap_q.regs.gen;
	assign rsp.recent_error     = snap_q.regs.error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			snap_q <= snap;
		end
	end
endmodule

@@ src/measurement_mode_controller_unit.sv @@
// measurement_mode_controller_unit: top level of the measurement mode controller
// depends on mmc_pkg, mmc_if, mmc_in_stage, mmc_core, mmc_out_stage
//
// channel  dir  item
// cmd      in   command, requested_mode, request_id, error_code, frame_sequence,
//               duration_us
// rsp      out  accepted plus full state snapshot after the command
//
// one item per clock while rsp is ready; rsp valid comes from the result register
// input register, then the guarded update and the result register in the same cycle
// controller registers update when an item moves from the input register to the result
// asynchronous reset puts the controller in safe with all modes none and counts zero
// a stalled rsp holds its item; cmd keeps accepting until both registers are full
module measurement_mode_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	mmc_cmd_if.sink     cmd,
	mmc_snap_if.source  rsp
);
	import mmc_pkg::*;

	logic       advance;
	logic       space;
	cmd_item_t  item_s1;
	snap_item_t snap;

	mmc_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.space   (space),
		.advance (advance),
		.item_s1 (item_s1)
	);

	mmc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.snap    (snap)
	);

	mmc_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.snap    (snap),
		.space   (space),
		.rsp     (rsp)
	);
endmodule
